>>> hdl/polynomial_rolling_hash_core_macros.svh
// Assertion macros shared by the rolling hash RTL.
`ifndef POLYNOMIAL_ROLLING_HASH_CORE_MACROS_SVH
`define POLYNOMIAL_ROLLING_HASH_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRH_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRH_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/prh_pkg.sv
// Types, constants and helpers for the rolling hash core.
package prh_pkg;

   localparam int BYTE_W = 8;
   localparam int HASH_W = 64;
   localparam int LEN_W = 7;
   localparam int WINDOW_MAX_DEF = 64;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = 7'd4;
   localparam logic [HASH_W-1:0] DROP_WEIGHT_RESET = 64'd2248091;
   // drop weight times the base, kept alongside the register
   localparam logic [HASH_W-1:0] DROP_SCALED_RESET = 64'd294499921;

   typedef enum logic {
      REG_WINDOW_LEN  = 1'b0,
      REG_DROP_WEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              restart;
   } req_type;

   typedef struct packed {
      logic [HASH_W-1:0] hash_value;
      logic              window_full;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0]  eff_len;
      logic [LEN_W-1:0]  tap_pos;
      logic [HASH_W-1:0] drop_scaled;
      logic              hold;
   } cfg_type;

   // Multiply by the hash base 131 with shifts and adds, wrapping at 64 bits.
   function automatic logic [HASH_W-1:0] mul_base(input logic [HASH_W-1:0] x);
      return (x << 7) + (x << 1) + x;
   endfunction

endpackage

>>> hdl/prh_cell.sv
// One cell of the window chain: holds a byte and passes it on each beat.
module prh_cell #(
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  logic                      shift_en,
   input  logic [prh_pkg::BYTE_W-1:0] byte_in,
   input  logic [prh_pkg::LEN_W-1:0]  tap_pos,
   output logic [prh_pkg::BYTE_W-1:0] byte_out,
   output logic [prh_pkg::BYTE_W-1:0] tap_byte
);

   logic [prh_pkg::BYTE_W-1:0] byte_ff;
   logic [prh_pkg::BYTE_W-1:0] byte_in_next;
   logic                       tap_hit;

   always_comb begin
      byte_in_next = shift_en ? byte_in : byte_ff;
      tap_hit = (32'(tap_pos) == INDEX);
      // present the value this cell will hold, so the product is ready a beat early
      tap_byte = tap_hit ? byte_in_next : '0;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_next;
   end

   assign byte_out = byte_ff;

endmodule

>>> hdl/prh_csr.sv
// Configuration registers: window length and drop weight.
module prh_csr #(
   parameter int WINDOW_MAX = prh_pkg::WINDOW_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [prh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [prh_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [prh_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output prh_pkg::cfg_type              cfg
);

   logic [prh_pkg::LEN_W-1:0]  len_ff;
   logic [prh_pkg::LEN_W-1:0]  len_in;
   logic [prh_pkg::HASH_W-1:0] weight_ff;
   logic [prh_pkg::HASH_W-1:0] weight_in;
   logic [prh_pkg::HASH_W-1:0] scaled_ff;
   logic [prh_pkg::HASH_W-1:0] scaled_in;
   logic                       hold_ff;
   logic                       hold_in;
   logic                       wr;
   prh_pkg::reg_index_type     sel;
   logic [prh_pkg::LEN_W-1:0]  eff_len;

   assign wr = csr_psel & csr_penable & csr_pwrite;
   assign sel = prh_pkg::reg_index_type'(csr_paddr[3]);

   always_comb begin
      len_in = len_ff;
      weight_in = weight_ff;
      scaled_in = scaled_ff;
      hold_in = wr;
      if (wr) begin
         case (sel)
            prh_pkg::REG_WINDOW_LEN: begin
               len_in = csr_pwdata[prh_pkg::LEN_W-1:0];
            end
            prh_pkg::REG_DROP_WEIGHT: begin
               weight_in = csr_pwdata;
               scaled_in = prh_pkg::mul_base(csr_pwdata);
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= prh_pkg::WINDOW_LEN_RESET;
         weight_ff <= prh_pkg::DROP_WEIGHT_RESET;
         scaled_ff <= prh_pkg::DROP_SCALED_RESET;
         hold_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         weight_ff <= weight_in;
         scaled_ff <= scaled_in;
         hold_ff <= hold_in;
      end
   end

   // clamp out-of-range lengths to one and to the chain depth
   always_comb begin
      if (len_ff == '0) begin
         eff_len = prh_pkg::LEN_W'(1);
      end else if (32'(len_ff) > WINDOW_MAX) begin
         eff_len = prh_pkg::LEN_W'(WINDOW_MAX);
      end else begin
         eff_len = len_ff;
      end
   end

   always_comb begin
      case (sel)
         prh_pkg::REG_WINDOW_LEN: begin
            csr_prdata = {{(prh_pkg::CSR_DATA_W-prh_pkg::LEN_W){1'b0}}, len_ff};
         end
         prh_pkg::REG_DROP_WEIGHT: begin
            csr_prdata = weight_ff;
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg.eff_len = eff_len;
   assign cfg.tap_pos = eff_len - prh_pkg::LEN_W'(1);
   assign cfg.drop_scaled = scaled_ff;
   assign cfg.hold = hold_ff;

endmodule

>>> hdl/prh_update.sv
// Hash update loop, fill count, drop product and result register.
`include "polynomial_rolling_hash_core_macros.svh"

module prh_update (
   input  logic                       clock,
   input  logic                       reset,
   input  prh_pkg::cfg_type           cfg,
   input  logic                       req_valid,
   input  prh_pkg::req_type           req_data,
   input  logic [prh_pkg::BYTE_W-1:0] tap_byte,
   input  logic                       rsp_stall,
   output logic                       req_stall,
   output logic                       accept,
   output logic                       rsp_valid,
   output prh_pkg::rsp_type           rsp_data
);

   logic [prh_pkg::HASH_W-1:0] hash_ff;
   logic [prh_pkg::HASH_W-1:0] hash_in;
   logic [prh_pkg::LEN_W-1:0]  fill_ff;
   logic [prh_pkg::LEN_W-1:0]  fill_in;
   logic [prh_pkg::HASH_W-1:0] term_ff;
   logic [prh_pkg::HASH_W-1:0] term_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   prh_pkg::rsp_type           rsp_ff;
   prh_pkg::rsp_type           rsp_in;
   logic [prh_pkg::HASH_W-1:0] hash_base;
   logic [prh_pkg::LEN_W-1:0]  fill_base;
   logic [prh_pkg::HASH_W-1:0] hash_scaled;
   logic [prh_pkg::HASH_W-1:0] byte_ext;
   logic                       full_before;

   // refuse beats in reset, after a register write, or while a stalled result waits
   assign req_stall = reset | cfg.hold | (rsp_valid_ff & rsp_stall);
   assign accept = req_valid & ~req_stall;

   // oldest byte times drop weight times base, for the next beat
   assign term_in = cfg.drop_scaled * prh_pkg::HASH_W'(tap_byte);

   always_comb begin
      hash_base = req_data.restart ? '0 : hash_ff;
      fill_base = req_data.restart ? '0 : fill_ff;
      full_before = (fill_base >= cfg.eff_len);
      hash_scaled = prh_pkg::mul_base(hash_base);
      byte_ext = {{(prh_pkg::HASH_W-prh_pkg::BYTE_W){1'b0}}, req_data.in_byte};
      hash_in = hash_ff;
      fill_in = fill_ff;
      rsp_in = rsp_ff;
      if (accept) begin
         if (full_before) begin
            hash_in = hash_scaled - term_ff + byte_ext;
            fill_in = fill_base;
         end else begin
            hash_in = hash_scaled + byte_ext;
            fill_in = fill_base + prh_pkg::LEN_W'(1);
         end
         rsp_in.hash_value = hash_in;
         rsp_in.window_full = (fill_in >= cfg.eff_len);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         fill_ff <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `PRH_ASSERT_NEXT(a_restart_fill, clock, reset, accept && req_data.restart,
      fill_ff == prh_pkg::LEN_W'(1), "restart beat did not leave one byte in window")
   `PRH_ASSERT_NEXT(a_restart_hash, clock, reset, accept && req_data.restart,
      hash_ff == {{(prh_pkg::HASH_W-prh_pkg::BYTE_W){1'b0}}, $past(req_data.in_byte)},
      "restart beat hash is not the byte")
   `PRH_ASSERT_NEXT(a_accept_result, clock, reset, accept,
      rsp_valid_ff && rsp_ff.hash_value == hash_ff, "accepted beat did not load result")

endmodule

>>> hdl/polynomial_rolling_hash_core.sv
// Top level of the rolling hash core: registers, window chain and hash loop.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_data  (in_byte, restart)
//   rsp      out  rsp_valid/rsp_stall  rsp_data  (hash_value, window_full)
//   csr      in   APB psel/penable     64-bit registers at 0x0 and 0x8
//
// One byte per cycle when not stalled; a result shows in the cycle after its byte.
// Hash loop per accepted byte: times 131, minus drop product once full, plus byte.
// The drop product is registered ahead of the next byte from the tap at eff_len - 1.
// A register write holds req_stall for one cycle. rsp_stall backs up into req_stall.
// Reset is synchronous and holds req_stall high; the chain is not cleared.
`include "polynomial_rolling_hash_core_macros.svh"

module polynomial_rolling_hash_core #(
   parameter int WINDOW_MAX = prh_pkg::WINDOW_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  prh_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output prh_pkg::rsp_type              rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [prh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [prh_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [prh_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);

   prh_pkg::cfg_type           cfg;
   logic                       accept;
   logic [prh_pkg::BYTE_W-1:0] chain [WINDOW_MAX];
   logic [prh_pkg::BYTE_W-1:0] taps [WINDOW_MAX];
   logic [prh_pkg::BYTE_W-1:0] tap_byte;

   prh_csr #(
      .WINDOW_MAX(WINDOW_MAX)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg)
   );

   for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
      if (k == 0) begin : g_head
         prh_cell #(
            .INDEX(k)
         ) u_cell (
            .clock   (clock),
            .shift_en(accept),
            .byte_in (req_data.in_byte),
            .tap_pos (cfg.tap_pos),
            .byte_out(chain[k]),
            .tap_byte(taps[k])
         );
      end else begin : g_body
         prh_cell #(
            .INDEX(k)
         ) u_cell (
            .clock   (clock),
            .shift_en(accept),
            .byte_in (chain[k-1]),
            .tap_pos (cfg.tap_pos),
            .byte_out(chain[k]),
            .tap_byte(taps[k])
         );
      end
   end

   // only the selected cell drives a nonzero tap
   always_comb begin
      tap_byte = '0;
      for (int k = 0; k < WINDOW_MAX; k++) begin
         tap_byte = tap_byte | taps[k];
      end
   end

   prh_update u_update (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_valid(req_valid),
      .req_data (req_data),
      .tap_byte (tap_byte),
      .rsp_stall(rsp_stall),
      .req_stall(req_stall),
      .accept   (accept),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   `PRH_ASSERT_NEXT(a_cfg_hold, clock, reset, csr_psel && csr_penable && csr_pwrite,
      req_stall, "request taken right after a register write")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the rolling hash core: stream, window and register coverage.
`timescale 1ns / 1ps

module testbench;

   localparam int PHASE_ITEMS    = 130;
   localparam int QUIET_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct packed {
      logic [prh_pkg::BYTE_W-1:0] in_byte;
      logic                       restart;
      logic                       known;
      logic [prh_pkg::HASH_W-1:0] hash_value;
      logic                       window_full;
   } stim_row_type;

   // Rows with a typed result follow from the reset setting (length 4, weight 131^3).
   localparam stim_row_type DIRECTED [17] = '{
      '{8'hFF, 1'b0, 1'b1, 64'd255,       1'b0},
      '{8'h00, 1'b0, 1'b1, 64'd33405,     1'b0},
      '{8'h00, 1'b0, 1'b1, 64'd4376055,   1'b0},
      '{8'h00, 1'b0, 1'b1, 64'd573263205, 1'b1},
      '{8'h00, 1'b0, 1'b1, 64'd0,         1'b1},
      '{8'h01, 1'b0, 1'b0, 64'd0,         1'b0},
      '{8'h80, 1'b0, 1'b0, 64'd0,         1'b0},
      '{8'hFF, 1'b0, 1'b0, 64'd0,         1'b0},
      '{8'h7F, 1'b0, 1'b0, 64'd0,         1'b0},
      '{8'hFE, 1'b0, 1'b0, 64'd0,         1'b0},
      '{8'hFF, 1'b1, 1'b1, 64'd255,       1'b0},
      '{8'h00, 1'b1, 1'b1, 64'd0,         1'b0},
      '{8'hAA, 1'b0, 1'b0, 64'd0,         1'b0},
      '{8'h55, 1'b0, 1'b0, 64'd0,         1'b0},
      '{8'h00, 1'b0, 1'b0, 64'd0,         1'b0},
      '{8'hFF, 1'b0, 1'b0, 64'd0,         1'b0},
      '{8'h01, 1'b1, 1'b1, 64'd1,         1'b0}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   prh_pkg::req_type               req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   prh_pkg::rsp_type               rsp_data;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [prh_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [prh_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [prh_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // Expectation override travels with the beat so it is sampled at the same edge.
   logic                           item_known = 1'b0;
   prh_pkg::rsp_type               item_value = '0;
   bit                             calm_mode = 1'b0;

   // Shadow of the block's state and registers.
   logic [prh_pkg::BYTE_W-1:0]     win_bytes [prh_pkg::WINDOW_MAX_DEF] = '{default: '0};
   logic [5:0]                     win_head = '0;
   int unsigned                    win_fill = 0;
   logic [prh_pkg::HASH_W-1:0]     hash_acc = '0;
   logic [prh_pkg::LEN_W-1:0]      cfg_len = prh_pkg::WINDOW_LEN_RESET;
   logic [prh_pkg::HASH_W-1:0]     cfg_drop = prh_pkg::DROP_WEIGHT_RESET;

   prh_pkg::rsp_type               hash_due [$];
   int                             bytes_in = 0;
   int                             results_out = 0;
   int                             fail_count = 0;
   int                             quiet_cycles = 0;
   int                             phase_count = 0;

   polynomial_rolling_hash_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   function automatic int unsigned span_of(input logic [prh_pkg::LEN_W-1:0] len);
      if (len == 0) return 1;
      if (32'(len) > prh_pkg::WINDOW_MAX_DEF) return prh_pkg::WINDOW_MAX_DEF;
      return 32'(len);
   endfunction

   function automatic logic [prh_pkg::HASH_W-1:0] weight_for_span(input int unsigned span);
      logic [prh_pkg::HASH_W-1:0] p;
      p = 64'd1;
      repeat (span - 1) p = p * 64'd131;
      return p;
   endfunction

   function automatic prh_pkg::rsp_type roll_hash(input prh_pkg::req_type item);
      int unsigned      span;
      logic [5:0]       tap;
      prh_pkg::rsp_type res;
      span = span_of(cfg_len);
      if (item.restart) begin
         hash_acc = '0;
         win_fill = 0;
         win_head = '0;
      end
      if (win_fill >= span) begin
         // drop the byte that entered span beats ago
         tap = win_head - 6'(span);
         hash_acc = (hash_acc - cfg_drop * 64'(win_bytes[tap])) * 64'd131
                    + 64'(item.in_byte);
      end else begin
         hash_acc = hash_acc * 64'd131 + 64'(item.in_byte);
         win_fill++;
      end
      win_bytes[win_head] = item.in_byte;
      win_head++;
      res.hash_value  = hash_acc;
      res.window_full = (win_fill >= span);
      return res;
   endfunction

   function automatic int idle_gap();
      int gap;
      gap = 0;
      if (calm_mode) return 0;
      while ($urandom_range(99) < 20) gap++;
      return gap;
   endfunction

   always @(posedge clock) begin
      rsp_stall <= !calm_mode && ($urandom_range(99) < 20);
   end

   always @(posedge clock) begin : monitor
      prh_pkg::rsp_type guess;
      prh_pkg::rsp_type due;
      logic             active;
      active = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            guess = roll_hash(req_data);
            hash_due.push_back(item_known ? item_value : guess);
            bytes_in++;
            active = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            active = 1'b1;
            results_out++;
            if (hash_due.size() == 0) begin
               $error("rsp beat with nothing expected: hash_value %h window_full %b",
                      rsp_data.hash_value, rsp_data.window_full);
               fail_count++;
            end else begin
               due = hash_due.pop_front();
               if (due.hash_value !== rsp_data.hash_value) begin
                  $error("hash_value: expected %h, got %h",
                         due.hash_value, rsp_data.hash_value);
                  fail_count++;
               end
               if (due.window_full !== rsp_data.window_full) begin
                  $error("window_full: expected %b, got %b",
                         due.window_full, rsp_data.window_full);
                  fail_count++;
               end
            end
         end
      end
      if (csr_psel && csr_penable && csr_pready) active = 1'b1;
      quiet_cycles = active ? 0 : quiet_cycles + 1;
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("testbench: watchdog expired after %0d idle cycles", QUIET_LIMIT);
      $display("testbench: done, errors");
      $finish;
   end

   task automatic send(input prh_pkg::req_type item, input logic known,
                       input prh_pkg::rsp_type value);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_data   <= item;
      item_known <= known;
      item_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Hold off the sender until every outstanding hash has come back.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (hash_due.size() != 0) @(posedge clock);
   endtask

   // Leaves psel high between accesses; the caller drops it after the last one.
   task automatic csr_access(input prh_pkg::reg_index_type idx, input logic wr,
                             input logic [prh_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [prh_pkg::CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
   endtask

   task automatic run_phase(input logic [prh_pkg::LEN_W-1:0] len,
                            input logic [prh_pkg::HASH_W-1:0] drop,
                            input bit calm);
      logic [prh_pkg::CSR_DATA_W-1:0] back;
      int unsigned                    span;
      int                             seg_left;
      prh_pkg::req_type               item;
      calm_mode <= calm;
      csr_access(prh_pkg::REG_WINDOW_LEN, 1'b1, 64'(len), back);
      csr_access(prh_pkg::REG_DROP_WEIGHT, 1'b1, drop, back);
      csr_access(prh_pkg::REG_WINDOW_LEN, 1'b0, '0, back);
      if (back[prh_pkg::LEN_W-1:0] !== len) begin
         $error("window_len: expected %0d, got %0d", len, back[prh_pkg::LEN_W-1:0]);
         fail_count++;
      end
      csr_access(prh_pkg::REG_DROP_WEIGHT, 1'b0, '0, back);
      if (back !== drop) begin
         $error("drop_weight: expected %h, got %h", drop, back);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg_len  = len;
      cfg_drop = drop;
      phase_count++;

      // Streams long enough to fill and roll the window; a first segment without
      // restart carries the old window across the length change.
      span = span_of(len);
      seg_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         item.restart = 1'b0;
         if (seg_left == 0) begin
            seg_left = $urandom_range(3 * span + 4, 1);
            item.restart = ($urandom_range(4) != 0);
         end else if ($urandom_range(99) < 2) begin
            item.restart = 1'b1;
         end
         seg_left--;
         case ($urandom_range(9))
            0: begin
               item.in_byte = 8'h00;
            end
            1: begin
               item.in_byte = 8'hFF;
            end
            default: begin
               item.in_byte = 8'($urandom_range(255));
            end
         endcase
         send(item, 1'b0, '0);
      end
      settle();
   endtask

   initial begin : stimulus
      logic [prh_pkg::LEN_W-1:0] pick;
      prh_pkg::rsp_type          typed;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         typed.hash_value  = DIRECTED[i].hash_value;
         typed.window_full = DIRECTED[i].window_full;
         send('{in_byte: DIRECTED[i].in_byte, restart: DIRECTED[i].restart},
              DIRECTED[i].known, typed);
      end
      settle();

      run_phase(7'd1, weight_for_span(1), 1'b0);
      run_phase(7'd64, weight_for_span(64), 1'b1);
      run_phase(7'd0, 64'd1, 1'b0);
      run_phase(7'd127, weight_for_span(64), 1'b0);
      run_phase(7'd65, weight_for_span(64), 1'b0);
      run_phase(7'd4, 64'd0, 1'b0);
      run_phase(7'd7, '1, 1'b0);
      repeat (3) begin
         pick = 7'($urandom_range(prh_pkg::WINDOW_MAX_DEF, 1));
         run_phase(pick, weight_for_span(span_of(pick)), 1'b0);
      end
      pick = 7'($urandom_range(prh_pkg::WINDOW_MAX_DEF, 1));
      run_phase(pick, {32'($urandom), 32'($urandom)}, 1'b0);

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("testbench: %0d bytes hashed, %0d results checked across %0d window settings",
               bytes_in, results_out, phase_count);
      $display("testbench: lengths 0 to 127, restarts, length changes mid-stream, odd weights");
      if (fail_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
